FILE: hdl/rcws_pkg.sv
// shared types, codes and defaults for the raycast wall column shader
package rcws_pkg;

   localparam int SCREEN_HEIGHT_DEF = 1024;
   localparam int TILE_SIZE_DEF     = 64;
   localparam int ANGLE_BITS_DEF    = 16;

   localparam logic [10:0] TEX_HEIGHT_RST  = 11'd64;
   localparam logic [10:0] TEX_WIDTH_RST   = 11'd64;
   localparam logic [15:0] PROJ_SCALE_RST  = 16'd50000;
   localparam logic [23:0] CEIL_COLOR_RST  = 24'h87CEEB;
   localparam logic [23:0] FLOOR_COLOR_RST = 24'h696969;

   localparam logic [2:0] CSR_TEX_HEIGHT  = 3'd0;
   localparam logic [2:0] CSR_TEX_WIDTH   = 3'd1;
   localparam logic [2:0] CSR_PROJ_SCALE  = 3'd2;
   localparam logic [2:0] CSR_CEIL_COLOR  = 3'd3;
   localparam logic [2:0] CSR_FLOOR_COLOR = 3'd4;

   localparam logic [1:0] TEX_EAST  = 2'd0;
   localparam logic [1:0] TEX_WEST  = 2'd1;
   localparam logic [1:0] TEX_NORTH = 2'd2;
   localparam logic [1:0] TEX_SOUTH = 2'd3;

   typedef enum logic [1:0] {
      KIND_CEILING = 2'd0,
      KIND_FLOOR   = 2'd1,
      KIND_WALL    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [9:0] row;
      logic       vertical;
      logic [1:0] sel;
   } base_type;

endpackage

FILE: hdl/rcws_div.sv
// pipelined restoring divider, one quotient bit per stage, with side payload
module rcws_div #(
   parameter int NW = 32,
   parameter int DW = 24,
   parameter int QW = 32,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [DW-1:0] out_rem,
   output logic [PW-1:0] out_pay
);

   logic          vld_st  [QW+1];
   logic [DW-1:0] rem_st  [QW+1];
   logic [DW-1:0] den_st  [QW+1];
   logic [QW-1:0] numl_st [QW+1];
   logic [QW-1:0] quo_st  [QW+1];
   logic [PW-1:0] pay_st  [QW+1];

   // quotient is known to fit, so the top part is already below the divisor
   assign vld_st[0]  = in_valid;
   assign rem_st[0]  = DW'(in_num >> QW);
   assign den_st[0]  = in_den;
   assign numl_st[0] = in_num[QW-1:0];
   assign quo_st[0]  = '0;
   assign pay_st[0]  = in_pay;

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic          vld_ff;
      logic [DW-1:0] rem_ff, rem_in;
      logic [DW-1:0] den_ff;
      logic [QW-1:0] numl_ff, numl_in;
      logic [QW-1:0] quo_ff, quo_in;
      logic [PW-1:0] pay_ff;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      always_comb begin
         trial   = {rem_st[s], numl_st[s][QW-1]};
         diff    = trial - {1'b0, den_st[s]};
         ge      = trial >= {1'b0, den_st[s]};
         rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in  = QW'({quo_st[s], ge});
         numl_in = QW'({numl_st[s], 1'b0});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_st[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            den_ff  <= den_st[s];
            numl_ff <= numl_in;
            quo_ff  <= quo_in;
            pay_ff  <= pay_st[s];
         end
      end

      assign vld_st[s+1]  = vld_ff;
      assign rem_st[s+1]  = rem_ff;
      assign den_st[s+1]  = den_ff;
      assign numl_st[s+1] = numl_ff;
      assign quo_st[s+1]  = quo_ff;
      assign pay_st[s+1]  = pay_ff;
   end

   assign out_valid = vld_st[QW];
   assign out_quo   = quo_st[QW];
   assign out_rem   = rem_st[QW];
   assign out_pay   = pay_st[QW];

endmodule

FILE: hdl/raycast_wall_column_shader.sv
// Raycast wall column shader: top level. Takes one pixel transfer per clock unless stalled
// and returns one result per pixel in order. Most stages lie in the three one-bit-per-stage
// dividers (cosine, wall height, texture row); the texture column comes from reciprocal
// multiplies in stages u1 to cc. A stall on the result side holds the whole pipeline;
// nothing is dropped. The user must write registers only while idle; nothing enforces it.
module raycast_wall_column_shader #(
   parameter int SCREEN_HEIGHT = rcws_pkg::SCREEN_HEIGHT_DEF,
   parameter int TILE_SIZE     = rcws_pkg::TILE_SIZE_DEF,
   parameter int ANGLE_BITS    = rcws_pkg::ANGLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_row,
   input  logic [23:0] req_dist_horizontal,
   input  logic [23:0] req_dist_vertical,
   input  logic [23:0] req_hit_x_on_horizontal,
   input  logic [23:0] req_hit_y_on_vertical,
   input  logic [15:0] req_ray_angle,
   input  logic [15:0] req_view_angle,
   input  logic        req_faces_right,
   input  logic        req_faces_left,
   input  logic        req_faces_up,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_pixel_kind,
   output logic [23:0] rsp_fill_color,
   output logic [1:0]  rsp_texture_select,
   output logic [19:0] rsp_texel_index,
   output logic        rsp_hit_is_vertical,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import rcws_pkg::*;

   localparam int          SPAN  = TILE_SIZE * 256;
   localparam int          SPANW = $clog2(SPAN + 1);
   localparam int          SPANX = SPANW + 1;
   localparam int          PW_B  = SPANW + 11;
   localparam int          SH_MOD = 24;
   localparam int          SH_COL = PW_B;
   localparam logic [SPANW:0] SPAN_X = SPANX'(SPAN);
   localparam logic [13:0] M_MOD = 14'((1 << SH_MOD) / SPAN);
   localparam logic [12:0] M_COL = 13'((1 << SH_COL) / SPAN);
   localparam int          HALF  = SCREEN_HEIGHT / 2;
   localparam logic [34:0] HALF512 = 35'(HALF * 512);
   localparam logic [15:0] AMASK = 16'(17'h0FFFF << (16 - ANGLE_BITS));
   localparam logic signed [26:0] SH_S = 27'(SCREEN_HEIGHT);

   typedef struct packed {
      base_type    base;
      logic [23:0] hit_dist;
      logic [28:0] p;
   } pay_a_type;

   typedef struct packed {
      base_type    base;
      logic [23:0] hit_dist;
      logic [10:0] tcol;
   } pay_c_type;

   typedef struct packed {
      base_type    base;
      logic [10:0] tcol;
   } pay_h_type;

   typedef struct packed {
      kind_type    kind;
      logic [23:0] fill;
      logic        sat;
      base_type    base;
      logic [10:0] tcol;
   } pay_t_type;

   logic en;

   // configuration
   logic [10:0] th_ff, tw_ff;
   logic [15:0] ps_ff;
   logic [23:0] ceil_ff, floor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         th_ff    <= TEX_HEIGHT_RST;
         tw_ff    <= TEX_WIDTH_RST;
         ps_ff    <= PROJ_SCALE_RST;
         ceil_ff  <= CEIL_COLOR_RST;
         floor_ff <= FLOOR_COLOR_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TEX_HEIGHT:  th_ff    <= csr_wdata[10:0];
            CSR_TEX_WIDTH:   tw_ff    <= csr_wdata[10:0];
            CSR_PROJ_SCALE:  ps_ff    <= csr_wdata[15:0];
            CSR_CEIL_COLOR:  ceil_ff  <= csr_wdata;
            CSR_FLOOR_COLOR: floor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless the result register is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage a: hit choice, angle, cosine product
   logic        vert_c;
   logic [15:0] alpha_c;
   logic [14:0] t_c;
   logic [15:0] tc_c;
   logic [30:0] p_full_c;
   logic [1:0]  sel_c;

   always_comb begin
      vert_c   = !(req_dist_horizontal < req_dist_vertical);
      alpha_c  = (req_ray_angle - req_view_angle) & AMASK;
      t_c      = 15'(alpha_c + 16'd16384);
      tc_c     = 16'd32768 - {1'b0, t_c};
      p_full_c = {16'b0, t_c} * {15'b0, tc_c};
      if (vert_c && req_faces_right) begin
         sel_c = TEX_EAST;
      end else if (vert_c && req_faces_left) begin
         sel_c = TEX_WEST;
      end else if (!vert_c && req_faces_up) begin
         sel_c = TEX_NORTH;
      end else begin
         sel_c = TEX_SOUTH;
      end
   end

   logic        a_vld_ff;
   pay_a_type   a_pay_ff;
   logic [23:0] a_coord_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_pay_ff.base.row      <= req_row;
         a_pay_ff.base.vertical <= vert_c;
         a_pay_ff.base.sel      <= sel_c;
         a_pay_ff.hit_dist      <= vert_c ? req_dist_vertical : req_dist_horizontal;
         a_pay_ff.p             <= p_full_c[28:0];
         a_coord_ff             <= vert_c ? req_hit_y_on_vertical : req_hit_x_on_horizontal;
      end
   end

   // stage u1: reciprocal estimate of the tile count, low by at most one
   logic [37:0] umul_c;
   logic        u1_vld_ff;
   logic [13:0] u1_q_ff;
   logic [23:0] u1_coord_ff;
   pay_a_type   u1_pay_ff;

   assign umul_c = {14'b0, a_coord_ff} * {24'b0, M_MOD};

   always_ff @(posedge clock) begin
      if (reset) begin
         u1_vld_ff <= 1'b0;
      end else if (en) begin
         u1_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u1_q_ff     <= umul_c[37:24];
         u1_coord_ff <= a_coord_ff;
         u1_pay_ff   <= a_pay_ff;
      end
   end

   // stage u2: partial remainder, below twice the span
   logic [31:0]    uqs_c, ur_c;
   logic           u2_vld_ff;
   logic [SPANW:0] u2_r_ff;
   pay_a_type      u2_pay_ff;

   always_comb begin
      uqs_c = {18'b0, u1_q_ff} * 32'(SPAN);
      ur_c  = {8'b0, u1_coord_ff} - uqs_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u2_vld_ff <= 1'b0;
      end else if (en) begin
         u2_vld_ff <= u1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u2_r_ff   <= ur_c[SPANW:0];
         u2_pay_ff <= u1_pay_ff;
      end
   end

   // stage u3: final offset within the tile
   logic [SPANW:0]   ur_sub_c;
   logic             u3_vld_ff;
   logic [SPANW-1:0] u3_u_ff, u3_u_in;
   pay_a_type        u3_pay_ff;

   assign ur_sub_c = u2_r_ff - SPAN_X;
   assign u3_u_in  = (u2_r_ff >= SPAN_X) ? ur_sub_c[SPANW-1:0] : u2_r_ff[SPANW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         u3_vld_ff <= 1'b0;
      end else if (en) begin
         u3_vld_ff <= u2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u3_u_ff   <= u3_u_in;
         u3_pay_ff <= u2_pay_ff;
      end
   end

   // stage b: scale offset by texture width
   logic                b_vld_ff;
   logic [SPANW+10:0]   b_prod_ff, b_prod_in;
   pay_a_type           b_pay_ff;

   assign b_prod_in = {11'b0, u3_u_ff} * {{SPANW{1'b0}}, tw_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= u3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_prod_ff <= b_prod_in;
         b_pay_ff  <= u3_pay_ff;
      end
   end

   // stage c1: reciprocal estimate of the texture column
   logic [PW_B+12:0] cmul_c;
   logic             c1_vld_ff;
   logic [10:0]      c1_q_ff;
   logic [PW_B-1:0]  c1_x_ff;
   pay_a_type        c1_pay_ff;

   assign cmul_c = {13'b0, b_prod_ff} * {{PW_B{1'b0}}, M_COL};

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
      end else if (en) begin
         c1_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_q_ff   <= cmul_c[SH_COL+10:SH_COL];
         c1_x_ff   <= b_prod_ff;
         c1_pay_ff <= b_pay_ff;
      end
   end

   // stage c2: partial remainder of the column estimate
   logic [PW_B-1:0] cqs_c, cr_c;
   logic            c2_vld_ff;
   logic [10:0]     c2_q_ff;
   logic [SPANW:0]  c2_r_ff;
   pay_a_type       c2_pay_ff;

   always_comb begin
      cqs_c = {{SPANW{1'b0}}, c1_q_ff} * PW_B'(SPAN);
      cr_c  = c1_x_ff - cqs_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_vld_ff <= 1'b0;
      end else if (en) begin
         c2_vld_ff <= c1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_q_ff   <= c1_q_ff;
         c2_r_ff   <= cr_c[SPANW:0];
         c2_pay_ff <= c1_pay_ff;
      end
   end

   // stage cc: column correction, cosine numerator and denominator
   logic        cc_vld_ff;
   logic [48:0] cc_num_ff;
   logic [32:0] cc_den_ff, cc_den_in;
   logic [10:0] tcol_c;
   pay_c_type   cc_pay_ff;

   assign cc_den_in = 33'd5368709120 - {2'b0, c2_pay_ff.p, 2'b0};
   assign tcol_c    = (c2_r_ff >= SPAN_X) ? c2_q_ff + 11'd1 : c2_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_vld_ff <= 1'b0;
      end else if (en) begin
         cc_vld_ff <= c2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cc_num_ff          <= {c2_pay_ff.p, 20'b0};
         cc_den_ff          <= cc_den_in;
         cc_pay_ff.base     <= c2_pay_ff.base;
         cc_pay_ff.hit_dist <= c2_pay_ff.hit_dist;
         cc_pay_ff.tcol     <= tcol_c;
      end
   end

   logic        cos_vld;
   logic [16:0] cos_quo;
   logic [32:0] cos_rem;
   pay_c_type   cos_pay;

   rcws_div #(.NW(49), .DW(33), .QW(17), .PW($bits(pay_c_type))) u_div_cos (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (cc_vld_ff),
      .in_num   (cc_num_ff),
      .in_den   (cc_den_ff),
      .in_pay   (cc_pay_ff),
      .out_valid(cos_vld),
      .out_quo  (cos_quo),
      .out_rem  (cos_rem),
      .out_pay  (cos_pay)
   );

   // stage m: corrected distance
   logic        m_vld_ff;
   logic [40:0] dcp_c;
   logic [23:0] dc_c;
   logic [23:0] m_dc_ff;
   logic [31:0] m_num_ff;
   pay_h_type   m_pay_ff;

   always_comb begin
      dcp_c = {17'b0, cos_pay.hit_dist} * {24'b0, cos_quo};
      dc_c  = (dcp_c[39:16] == 24'd0) ? 24'd1 : dcp_c[39:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff <= cos_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_dc_ff       <= dc_c;
         m_num_ff      <= {ps_ff, 16'b0};
         m_pay_ff.base <= cos_pay.base;
         m_pay_ff.tcol <= cos_pay.tcol;
      end
   end

   logic        h_vld;
   logic [31:0] h_quo;
   logic [23:0] h_rem;
   pay_h_type   h_pay;

   rcws_div #(.NW(32), .DW(24), .QW(32), .PW($bits(pay_h_type))) u_div_height (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (m_vld_ff),
      .in_num   (m_num_ff),
      .in_den   (m_dc_ff),
      .in_pay   (m_pay_ff),
      .out_valid(h_vld),
      .out_quo  (h_quo),
      .out_rem  (h_rem),
      .out_pay  (h_pay)
   );

   // stage e1: raw wall span
   logic signed [34:0] v_c, nv_c;
   logic signed [26:0] sraw_c, eraw_c;

   always_comb begin
      v_c    = signed'(HALF512 - {3'b0, h_quo});
      nv_c   = -v_c;
      sraw_c = v_c[34] ? -27'(nv_c >>> 9) : 27'(v_c >>> 9);
      eraw_c = sraw_c + signed'({3'b0, h_quo[31:8]});
   end

   logic               e1_vld_ff;
   logic signed [26:0] e1_sraw_ff, e1_eraw_ff;
   logic [31:0]        e1_h8_ff;
   pay_h_type          e1_pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
      end else if (en) begin
         e1_vld_ff <= h_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_sraw_ff <= sraw_c;
         e1_eraw_ff <= eraw_c;
         e1_h8_ff   <= h_quo;
         e1_pay_ff  <= h_pay;
      end
   end

   // stage e2: clamp, classify, texture row numerator
   logic signed [26:0] start_c, end_c, row_s_c;
   logic signed [34:0] tnum_c;
   kind_type           kind_c;
   logic [23:0]        fill_c;
   logic               tok_c;

   always_comb begin
      start_c = e1_sraw_ff[26] ? 27'sd0 : e1_sraw_ff;
      end_c   = (e1_eraw_ff > SH_S) ? SH_S : e1_eraw_ff;
      row_s_c = signed'({17'b0, e1_pay_ff.base.row});
      tnum_c  = signed'({16'b0, e1_pay_ff.base.row, 9'b0}) - signed'(HALF512)
                + signed'({3'b0, e1_h8_ff});
      tok_c   = (tnum_c > 35'sd0) && (e1_h8_ff != 32'd0) && (th_ff != 11'd0);
      if (row_s_c >= start_c && row_s_c < end_c) begin
         kind_c = KIND_WALL;
         fill_c = 24'd0;
      end else if (row_s_c <= start_c) begin
         kind_c = KIND_CEILING;
         fill_c = ceil_ff;
      end else begin
         kind_c = KIND_FLOOR;
         fill_c = floor_ff;
      end
   end

   logic        e2_vld_ff;
   logic [33:0] e2_tnum_ff;
   logic [31:0] e2_h8_ff;
   kind_type    e2_kind_ff;
   logic [23:0] e2_fill_ff;
   pay_h_type   e2_pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_vld_ff <= 1'b0;
      end else if (en) begin
         e2_vld_ff <= e1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e2_tnum_ff <= tok_c ? tnum_c[33:0] : 34'd0;
         e2_h8_ff   <= e1_h8_ff;
         e2_kind_ff <= kind_c;
         e2_fill_ff <= fill_c;
         e2_pay_ff  <= e1_pay_ff;
      end
   end

   // stage p: scaled numerator and doubled height
   logic        p_vld_ff;
   logic [44:0] p_prod_ff, p_prod_in;
   logic [32:0] p_den_ff, p_den_in;
   kind_type    p_kind_ff;
   logic [23:0] p_fill_ff;
   pay_h_type   p_pay_ff;

   assign p_prod_in = {11'b0, e2_tnum_ff} * {34'b0, th_ff};
   assign p_den_in  = (e2_h8_ff == 32'd0) ? 33'd1 : {e2_h8_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= e2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_prod_ff <= p_prod_in;
         p_den_ff  <= p_den_in;
         p_kind_ff <= e2_kind_ff;
         p_fill_ff <= e2_fill_ff;
         p_pay_ff  <= e2_pay_ff;
      end
   end

   // stage q: quotient past eleven bits saturates to the last row
   logic        sat_c;
   logic        q_vld_ff;
   logic [44:0] q_num_ff;
   logic [32:0] q_den_ff;
   pay_t_type   q_pay_ff;

   assign sat_c = p_prod_ff[44:11] >= {1'b0, p_den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (en) begin
         q_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_num_ff      <= sat_c ? 45'd0 : p_prod_ff;
         q_den_ff      <= p_den_ff;
         q_pay_ff.kind <= p_kind_ff;
         q_pay_ff.fill <= p_fill_ff;
         q_pay_ff.sat  <= sat_c;
         q_pay_ff.base <= p_pay_ff.base;
         q_pay_ff.tcol <= p_pay_ff.tcol;
      end
   end

   logic        tr_vld;
   logic [10:0] tr_quo;
   logic [32:0] tr_rem;
   pay_t_type   tr_pay;

   rcws_div #(.NW(45), .DW(33), .QW(11), .PW($bits(pay_t_type))) u_div_row (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (q_vld_ff),
      .in_num   (q_num_ff),
      .in_den   (q_den_ff),
      .in_pay   (q_pay_ff),
      .out_valid(tr_vld),
      .out_quo  (tr_quo),
      .out_rem  (tr_rem),
      .out_pay  (tr_pay)
   );

   // stage f: clamp texture row
   logic [10:0] th_m1_c, trow_c;
   logic        f_vld_ff;
   logic [10:0] f_trow_ff;
   pay_t_type   f_pay_ff;

   always_comb begin
      th_m1_c = th_ff - 11'd1;
      if (tr_pay.sat || tr_quo > th_m1_c) begin
         trow_c = th_m1_c;
      end else begin
         trow_c = tr_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff <= tr_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_trow_ff <= trow_c;
         f_pay_ff  <= tr_pay;
      end
   end

   // stage g: texel index and result register
   logic [21:0] tp_c, tsum_c;
   logic        g_wall_c;
   logic        g_vld_ff;
   logic [1:0]  g_kind_ff;
   logic [23:0] g_fill_ff;
   logic [1:0]  g_sel_ff;
   logic [19:0] g_texel_ff;
   logic        g_vert_ff;

   always_comb begin
      tp_c     = {11'b0, f_trow_ff} * {11'b0, th_ff};
      tsum_c   = tp_c + {11'b0, f_pay_ff.tcol};
      g_wall_c = (f_pay_ff.kind == KIND_WALL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (en) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_kind_ff  <= f_pay_ff.kind;
         g_fill_ff  <= f_pay_ff.fill;
         g_sel_ff   <= g_wall_c ? f_pay_ff.base.sel : TEX_EAST;
         g_texel_ff <= g_wall_c ? tsum_c[19:0] : 20'd0;
         g_vert_ff  <= f_pay_ff.base.vertical;
      end
   end

   assign rsp_valid           = g_vld_ff;
   assign rsp_pixel_kind      = g_kind_ff;
   assign rsp_fill_color      = g_fill_ff;
   assign rsp_texture_select  = g_sel_ff;
   assign rsp_texel_index     = g_texel_ff;
   assign rsp_hit_is_vertical = g_vert_ff;

endmodule
